@@ hw/rtl/mps_pkg.sv @@
// Package for the motor plant simulator: codes, widths and fixed-point helpers.
`default_nettype none
package mps_pkg;

	localparam int MUL_W  = 34;
	localparam int PROD_W = 68;
	localparam int SUM_W  = 70;
	localparam int REPORT_MAX = 16;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_POS  = 2'd1,
		MODE_VEL  = 2'd2,
		MODE_TRQ  = 2'd3
	} mode_t;

	localparam logic [2:0] ACT_POS  = 3'd0;
	localparam logic [2:0] ACT_VEL  = 3'd1;
	localparam logic [2:0] ACT_TRQ  = 3'd2;
	localparam logic [2:0] ACT_IDLE = 3'd3;
	localparam logic [2:0] ACT_TICK = 3'd4;
	localparam logic [2:0] ACT_READ = 3'd5;

	localparam logic [2:0] CFG_TICK_PERIOD = 3'd0;
	localparam logic [2:0] CFG_LAG_ALPHA   = 3'd1;
	localparam logic [2:0] CFG_INV_PERIOD  = 3'd2;
	localparam logic [2:0] CFG_TORQUE_STEP = 3'd3;
	localparam logic [2:0] CFG_DIST_AMP    = 3'd4;
	localparam logic [2:0] CFG_PHASE_STEP  = 3'd5;

	// Sine sequencer steps
	localparam logic [2:0] SK_Z2   = 3'd0;
	localparam logic [2:0] SK_P1   = 3'd1;
	localparam logic [2:0] SK_P4   = 3'd4;
	localparam logic [2:0] SK_ZP   = 3'd5;
	localparam logic [2:0] SK_AMP  = 3'd6;

	localparam logic [30:0] POLY_SEED = 31'd172271;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	// Odd polynomial coefficients, one per Horner step.
	function automatic logic [30:0] poly_coef(input logic [2:0] k);
		logic [30:0] c;
		case (k)
			3'd1: c = 31'd5026995;
			3'd2: c = 31'd85569306;
			3'd3: c = 31'd693598668;
			3'd4: c = 31'd1686629713;
			default: c = 31'd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > 70'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -70'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mps_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module mps_mul (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [mps_pkg::MUL_W-1:0]    a,
	input  wire logic signed [mps_pkg::MUL_W-1:0]    b,
	output logic signed      [mps_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= mps_pkg::PROD_W'(a) * mps_pkg::PROD_W'(b);
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/motor_plant_simulator.sv @@
// Top level of the motor plant simulator: sequencer, state memories and config.
// Command and idle items keep in_stall low; a read loads its result via ST_RDW.
// A tick evaluates the sine, then steps each motor through ST_MRD, ST_MCALC, the
// ST_M states its mode needs and ST_WB; the one shared 34x34 multiplier serialises this.
// One item at a time: in_stall stays high until a tick or read has finished.
// Reset (arst_n low) clears all motor state, mode, phase and restores register defaults.
`default_nettype none
module motor_plant_simulator #(
	parameter int MOTORS          = 16,
	parameter int SINE_TABLE_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic [3:0]         motor,
	input  wire logic signed [31:0] command_value,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              motor_id,
	output logic signed [31:0]      position,
	output logic signed [31:0]      velocity,
	output logic                    last,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int MW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int NREP = (MOTORS < mps_pkg::REPORT_MAX) ? MOTORS : mps_pkg::REPORT_MAX;
	localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b000000000001,
		ST_SIN_MUL = 12'b000000000010,
		ST_SIN_ACC = 12'b000000000100,
		ST_MRD     = 12'b000000001000,
		ST_MCALC   = 12'b000000010000,
		ST_M0      = 12'b000000100000,
		ST_M1      = 12'b000001000000,
		ST_M2      = 12'b000010000000,
		ST_M3      = 12'b000100000000,
		ST_M4      = 12'b001000000000,
		ST_WB      = 12'b010000000000,
		ST_RDW     = 12'b100000000000
	} state_t;

	state_t state_q;
	mps_pkg::mode_t mode_q;

	// configuration registers
	logic [31:0] tick_q;
	logic [16:0] alpha_q;
	logic [30:0] invp_q;
	logic [31:0] tstep_q;
	logic [30:0] amp_q;
	logic [31:0] pstep_q;
	logic [31:0] phase_q;

	// motor state memories with per-entry valid bits (invalid reads as zero)
	logic signed [31:0] pos_mem [MOTORS];
	logic signed [31:0] vel_mem [MOTORS];
	logic signed [31:0] pt_mem  [MOTORS];
	logic signed [31:0] vt_mem  [MOTORS];
	logic signed [31:0] tt_mem  [MOTORS];
	logic [MOTORS-1:0] pos_vld_q, vel_vld_q, pt_vld_q, vt_vld_q, tt_vld_q;

	logic signed [31:0] pos_rd_q, vel_rd_q, pt_rd_q, vt_rd_q, tt_rd_q;
	logic pos_rv_q, vel_rv_q, pt_rv_q, vt_rv_q, tt_rv_q;

	// sequencer datapath registers
	logic [MW-1:0]      m_q;
	logic [3:0]         mot_q;
	logic               ok_q;
	logic [2:0]         k_q;
	logic [30:0]        x_q;
	logic [30:0]        z2_q;
	logic [30:0]        acc_q;
	logic               neg_q;
	logic signed [16:0] sv_q;
	logic signed [33:0] dist_q;
	logic signed [31:0] p_q, v_q, vt_q, np_q, nv_q;
	logic signed [33:0] opa_q;

	// output register
	logic               out_valid_q;
	logic [3:0]         out_id_q;
	logic signed [31:0] out_pos_q, out_vel_q;
	logic               out_last_q;

	logic accept, ok_in, can_load, rep, wb_go, rd_en;
	logic [MW-1:0] raddr, waddr_in;
	logic mul_en;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;
	logic signed [31:0] pos_e, vel_e, pt_e, vt_e, tt_e;
	logic [16:0] alpha_c;
	logic [31:0] ph_cut;
	logic [31:0] s1;
	logic [17:0] s2;
	logic [16:0] s3;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign ok_in     = (32'(motor) < MOTORS);
	assign waddr_in  = MW'(motor);
	assign can_load  = !out_valid_q || !out_stall;
	assign rep       = (32'(m_q) < mps_pkg::REPORT_MAX);
	assign wb_go     = (state_q == ST_WB) && (!rep || can_load);
	assign rd_en     = (accept && action == mps_pkg::ACT_READ) || (state_q == ST_MRD);
	assign raddr     = (state_q == ST_MRD) ? m_q : waddr_in;
	assign alpha_c   = (alpha_q > mps_pkg::ALPHA_ONE) ? mps_pkg::ALPHA_ONE : alpha_q;
	assign ph_cut    = phase_q & PH_MASK;

	assign pos_e = pos_rv_q ? pos_rd_q : 32'sd0;
	assign vel_e = vel_rv_q ? vel_rd_q : 32'sd0;
	assign pt_e  = pt_rv_q  ? pt_rd_q  : 32'sd0;
	assign vt_e  = vt_rv_q  ? vt_rd_q  : 32'sd0;
	assign tt_e  = tt_rv_q  ? tt_rd_q  : 32'sd0;

	// rounding of the quarter-wave product to Q1.15
	assign s1 = prod_q[61:30];
	assign s2 = 18'((33'(s1) + 33'd16384) >> 15);
	assign s3 = (s2 > 18'd32767) ? 17'd32767 : s2[16:0];

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_SIN_MUL: begin
				mul_en = 1'b1;
				case (k_q)
					mps_pkg::SK_Z2: begin
						mul_a = $signed({3'b0, x_q});
						mul_b = $signed({3'b0, x_q});
					end
					mps_pkg::SK_P1: begin
						mul_a = $signed({3'b0, z2_q});
						mul_b = $signed({3'b0, mps_pkg::POLY_SEED});
					end
					mps_pkg::SK_ZP: begin
						mul_a = $signed({3'b0, x_q});
						mul_b = $signed({3'b0, acc_q});
					end
					mps_pkg::SK_AMP: begin
						mul_a = $signed({3'b0, amp_q});
						mul_b = 34'(sv_q);
					end
					default: begin
						mul_a = $signed({3'b0, z2_q});
						mul_b = $signed({3'b0, acc_q});
					end
				endcase
			end
			ST_M0: begin
				mul_en = 1'b1;
				mul_a  = opa_q;
				case (mode_q)
					mps_pkg::MODE_POS: mul_b = $signed({17'b0, alpha_c});
					mps_pkg::MODE_TRQ: mul_b = $signed({2'b0, tstep_q});
					default:           mul_b = $signed({2'b0, tick_q});
				endcase
			end
			ST_M3: begin
				mul_en = 1'b1;
				if (mode_q == mps_pkg::MODE_POS) begin
					mul_a = opa_q;
					mul_b = $signed({3'b0, invp_q});
				end else begin
					mul_a = 34'(nv_q);
					mul_b = $signed({2'b0, tick_q});
				end
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	mps_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= 32'd8589934;
			alpha_q <= 17'd65536;
			invp_q  <= 31'd32768000;
			tstep_q <= 32'd85899345;
			amp_q   <= 31'd19661;
			pstep_q <= 32'd2147484;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mps_pkg::CFG_TICK_PERIOD: tick_q  <= cfg_data;
				mps_pkg::CFG_LAG_ALPHA:   alpha_q <= cfg_data[16:0];
				mps_pkg::CFG_INV_PERIOD:  invp_q  <= cfg_data[30:0];
				mps_pkg::CFG_TORQUE_STEP: tstep_q <= cfg_data;
				mps_pkg::CFG_DIST_AMP:    amp_q   <= cfg_data[30:0];
				mps_pkg::CFG_PHASE_STEP:  pstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory writes: targets on command transactions, plant state at write-back
	always_ff @(posedge clk) begin
		if (accept && ok_in) begin
			case (action)
				mps_pkg::ACT_POS: pt_mem[waddr_in] <= command_value;
				mps_pkg::ACT_VEL: vt_mem[waddr_in] <= command_value;
				mps_pkg::ACT_TRQ: tt_mem[waddr_in] <= command_value;
				default: ;
			endcase
		end
		if (wb_go) begin
			pos_mem[m_q] <= np_q;
			vel_mem[m_q] <= nv_q;
		end
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_rd_q <= pos_mem[raddr];
			vel_rd_q <= vel_mem[raddr];
			pt_rd_q  <= pt_mem[raddr];
			vt_rd_q  <= vt_mem[raddr];
			tt_rd_q  <= tt_mem[raddr];
			pos_rv_q <= pos_vld_q[raddr];
			vel_rv_q <= vel_vld_q[raddr];
			pt_rv_q  <= pt_vld_q[raddr];
			vt_rv_q  <= vt_vld_q[raddr];
			tt_rv_q  <= tt_vld_q[raddr];
		end
	end

	// valid bits: reset clears all, commands and write-back set, idle clears every velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q <= '0;
			vel_vld_q <= '0;
			pt_vld_q  <= '0;
			vt_vld_q  <= '0;
			tt_vld_q  <= '0;
		end else begin
			if (accept) begin
				case (action)
					mps_pkg::ACT_POS:  if (ok_in) pt_vld_q[waddr_in] <= 1'b1;
					mps_pkg::ACT_VEL:  if (ok_in) vt_vld_q[waddr_in] <= 1'b1;
					mps_pkg::ACT_TRQ:  if (ok_in) tt_vld_q[waddr_in] <= 1'b1;
					mps_pkg::ACT_IDLE: vel_vld_q <= '0;
					default: ;
				endcase
			end
			if (wb_go) begin
				pos_vld_q[m_q] <= 1'b1;
				vel_vld_q[m_q] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= mps_pkg::MODE_IDLE;
			phase_q <= '0;
			m_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							mps_pkg::ACT_POS:  mode_q <= mps_pkg::MODE_POS;
							mps_pkg::ACT_VEL:  mode_q <= mps_pkg::MODE_VEL;
							mps_pkg::ACT_TRQ:  mode_q <= mps_pkg::MODE_TRQ;
							mps_pkg::ACT_IDLE: mode_q <= mps_pkg::MODE_IDLE;
							mps_pkg::ACT_TICK: begin
								k_q     <= mps_pkg::SK_Z2;
								m_q     <= '0;
								state_q <= ST_SIN_MUL;
							end
							mps_pkg::ACT_READ: state_q <= ST_RDW;
							default: ;
						endcase
					end
				end
				ST_SIN_MUL: state_q <= ST_SIN_ACC;
				ST_SIN_ACC: begin
					if (k_q == mps_pkg::SK_AMP) begin
						state_q <= ST_MRD;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_SIN_MUL;
					end
				end
				ST_MRD: state_q <= ST_MCALC;
				ST_MCALC: begin
					if (mode_q == mps_pkg::MODE_IDLE) begin
						state_q <= ST_WB;
					end else begin
						state_q <= ST_M0;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					case (mode_q)
						mps_pkg::MODE_POS: state_q <= ST_M2;
						mps_pkg::MODE_TRQ: state_q <= ST_M3;
						default:           state_q <= ST_WB;
					endcase
				end
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						if (m_q == MW'(MOTORS - 1)) begin
							phase_q <= phase_q + pstep_q;
							state_q <= ST_IDLE;
						end else begin
							m_q     <= m_q + MW'(1);
							state_q <= ST_MRD;
						end
					end
				end
				ST_RDW: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mot_q <= motor;
					ok_q  <= ok_in;
					neg_q <= ph_cut[31];
					x_q   <= ph_cut[30] ? (31'h40000000 - {1'b0, ph_cut[29:0]})
					                    : {1'b0, ph_cut[29:0]};
				end
			end
			ST_SIN_ACC: begin
				case (k_q)
					mps_pkg::SK_Z2: z2_q <= prod_q[60:30];
					mps_pkg::SK_ZP: sv_q <= neg_q ? -$signed(s3) : $signed(s3);
					mps_pkg::SK_AMP: dist_q <= 34'(prod_q >>> 15);
					default: acc_q <= mps_pkg::poly_coef(k_q) - prod_q[60:30];
				endcase
			end
			ST_MCALC: begin
				p_q  <= pos_e;
				v_q  <= vel_e;
				vt_q <= vt_e;
				np_q <= pos_e;
				nv_q <= 32'sd0;
				case (mode_q)
					mps_pkg::MODE_POS: opa_q <= 34'(pt_e) - 34'(pos_e);
					mps_pkg::MODE_VEL: opa_q <= 34'(vt_e);
					mps_pkg::MODE_TRQ:
						opa_q <= 34'(mps_pkg::sat32(70'(tt_e) + 70'(dist_q)));
					default: opa_q <= '0;
				endcase
			end
			ST_M1: begin
				case (mode_q)
					mps_pkg::MODE_POS: np_q <= mps_pkg::sat32(70'(p_q) + 70'(prod_q >>> 16));
					mps_pkg::MODE_VEL: begin
						np_q <= mps_pkg::sat32(70'(p_q) + 70'(prod_q >>> 32));
						nv_q <= vt_q;
					end
					mps_pkg::MODE_TRQ: nv_q <= mps_pkg::sat32(70'(v_q) + 70'(prod_q >>> 32));
					default: ;
				endcase
			end
			ST_M2: opa_q <= 34'(np_q) - 34'(p_q);
			ST_M4: begin
				if (mode_q == mps_pkg::MODE_POS) begin
					nv_q <= mps_pkg::sat32(70'(prod_q >>> 16));
				end else begin
					np_q <= mps_pkg::sat32(70'(p_q) + 70'(prod_q >>> 32));
				end
			end
			default: ;
		endcase
	end

	// output register: load a reported motor or a read result, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go && rep) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_RDW && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go && rep) begin
			out_id_q   <= 4'(m_q);
			out_pos_q  <= np_q;
			out_vel_q  <= nv_q;
			out_last_q <= (32'(m_q) == NREP - 1);
		end else if (state_q == ST_RDW && can_load) begin
			out_id_q   <= mot_q;
			out_pos_q  <= ok_q ? pos_e : 32'sd0;
			out_vel_q  <= ok_q ? vel_e : 32'sd0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_id  = out_id_q;
	assign position  = out_pos_q;
	assign velocity  = out_vel_q;
	assign last      = out_last_q;

`ifndef SYNTHESIS
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(mode_q))
		else $error("mode changed during a tick or read");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!wb_go |=> $stable(phase_q))
		else $error("phase moved outside tick write-back");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIN_MUL || state_q == ST_SIN_ACC) |-> (k_q <= mps_pkg::SK_AMP))
		else $error("sine step counter out of range");
	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> (32'(m_q) < MOTORS))
		else $error("motor counter out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_pos_q) && $stable(out_id_q))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

@@ tb/motor_plant_simulator_tb.sv @@
// Self-checking testbench for the motor plant simulator: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int NMOT = 16;
	localparam int TBITS = 8;
	localparam int LIMIT = 2000000;

	// Motor state record reported by a tick or read.
	typedef struct packed {
		logic [3:0]         id;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic               fin;
	} motor_report_t;

	int errors = 0;

	// Print one mismatch line and count it.
	task automatic report_error(input string msg);
		errors++;
		$display("ERROR %0t: %s", $realtime, msg);
	endtask

	// Clamp a wide signed value to 32 bits.
	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Products of 64-bit operands can exceed 64 bits, so shift 128-bit values.
	function automatic longint mul_shift(input longint a, input longint b, input int sh);
		logic signed [127:0] pr;
		pr = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		pr = pr >>> sh;
		if (pr > 128'sd9000000000000000000) return 64'sd9000000000000000000;
		if (pr < -128'sd9000000000000000000) return -64'sd9000000000000000000;
		return longint'(pr);
	endfunction

	// Quarter-wave sine, Q0.30 angle to Q1.15 magnitude.
	function automatic longint quarter_wave(input longint unsigned z);
		longint unsigned z2, p, s;
		z2 = (z * z) >> 30;
		p = 172271;
		p = 5026995 - ((z2 * p) >> 30);
		p = 85569306 - ((z2 * p) >> 30);
		p = 693598668 - ((z2 * p) >> 30);
		p = 1686629713 - ((z2 * p) >> 30);
		s = (z * p) >> 30;
		s = (s + 16384) >> 15;
		if (s > 32767) s = 32767;
		return longint'(s);
	endfunction

	function automatic longint sine_of(input logic [31:0] ph);
		logic [31:0] p;
		longint unsigned x;
		longint s;
		p = (ph >> (32 - TBITS)) << (32 - TBITS);
		x = p[29:0];
		if (p[30]) x = 64'h40000000 - x;
		s = quarter_wave(x);
		return p[31] ? -s : s;
	endfunction

	class motor_scoreboard;
		logic signed [31:0] pos_q[NMOT], vel_q[NMOT], ptgt[NMOT], vtgt[NMOT], ttgt[NMOT];
		mps_pkg::mode_t mode;
		logic [31:0] phase;
		logic [31:0] tick_period, inv_period, torque_step, dist_amp, phase_step;
		logic [16:0] lag_alpha;
		motor_report_t pending[$];
		int matched;

		function new();
			for (int i = 0; i < NMOT; i++) begin
				pos_q[i] = 0; vel_q[i] = 0; ptgt[i] = 0; vtgt[i] = 0; ttgt[i] = 0;
			end
			mode = mps_pkg::MODE_IDLE;
			phase = 0;
			tick_period = 8589934; lag_alpha = 65536; inv_period = 32768000;
			torque_step = 85899345; dist_amp = 19661; phase_step = 2147484;
			matched = 0;
		endfunction

		function void write_reg(input logic [2:0] idx, input logic [31:0] d);
			case (idx)
				mps_pkg::CFG_TICK_PERIOD: tick_period = d;
				mps_pkg::CFG_LAG_ALPHA:   lag_alpha = d[16:0];
				mps_pkg::CFG_INV_PERIOD:  inv_period = {1'b0, d[30:0]};
				mps_pkg::CFG_TORQUE_STEP: torque_step = d;
				mps_pkg::CFG_DIST_AMP:    dist_amp = {1'b0, d[30:0]};
				mps_pkg::CFG_PHASE_STEP:  phase_step = d;
				default: ;
			endcase
		endfunction

		function void step_motor(input int i, input longint disturb);
			longint p, v, a, np, nv, f, dt;
			p = pos_q[i]; v = vel_q[i]; dt = longint'({32'd0, tick_period});
			case (mode)
				mps_pkg::MODE_POS: begin
					a = lag_alpha > 65536 ? 65536 : longint'(lag_alpha);
					np = clamp32(p + mul_shift(longint'(ptgt[i]) - p, a, 16));
					vel_q[i] = 32'(clamp32(mul_shift(np - p,
						longint'({32'd0, inv_period}), 16)));
					pos_q[i] = 32'(np);
				end
				mps_pkg::MODE_VEL: begin
					v = vtgt[i];
					pos_q[i] = 32'(clamp32(p + mul_shift(v, dt, 32)));
					vel_q[i] = 32'(v);
				end
				mps_pkg::MODE_TRQ: begin
					f = clamp32(longint'(ttgt[i]) + disturb);
					nv = clamp32(v + mul_shift(f, longint'({32'd0, torque_step}), 32));
					vel_q[i] = 32'(nv);
					pos_q[i] = 32'(clamp32(p + mul_shift(nv, dt, 32)));
				end
				default: vel_q[i] = 0;
			endcase
		endfunction

		// Note an accepted input transaction and queue what it should produce.
		function void note_input(input logic [2:0] act, input logic [3:0] m,
				input logic signed [31:0] val);
			longint disturb;
			motor_report_t r;
			case (act)
				mps_pkg::ACT_POS: begin mode = mps_pkg::MODE_POS; ptgt[m] = val; end
				mps_pkg::ACT_VEL: begin mode = mps_pkg::MODE_VEL; vtgt[m] = val; end
				mps_pkg::ACT_TRQ: begin mode = mps_pkg::MODE_TRQ; ttgt[m] = val; end
				mps_pkg::ACT_IDLE: begin
					mode = mps_pkg::MODE_IDLE;
					for (int i = 0; i < NMOT; i++) vel_q[i] = 0;
				end
				mps_pkg::ACT_TICK: begin
					disturb = mul_shift(longint'({32'd0, dist_amp}), sine_of(phase), 15);
					for (int i = 0; i < NMOT; i++) step_motor(i, disturb);
					phase = phase + phase_step;
					for (int i = 0; i < NMOT; i++) begin
						r.id = 4'(i); r.pos = pos_q[i]; r.vel = vel_q[i];
						r.fin = (i == NMOT - 1);
						pending.push_back(r);
					end
				end
				mps_pkg::ACT_READ: begin
					r.id = m; r.pos = pos_q[m]; r.vel = vel_q[m]; r.fin = 1;
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		// Compare one output transaction with the oldest expectation.
		task check_output(input motor_report_t got);
			motor_report_t e;
			if (pending.size() == 0) begin
				report_error($sformatf("unexpected result for motor %0d", got.id));
				return;
			end
			e = pending.pop_front();
			if (got.id !== e.id)
				report_error($sformatf("motor_id got %0d want %0d", got.id, e.id));
			if (got.pos !== e.pos)
				report_error($sformatf("motor %0d position got %0d want %0d",
					e.id, got.pos, e.pos));
			if (got.vel !== e.vel)
				report_error($sformatf("motor %0d velocity got %0d want %0d",
					e.id, got.vel, e.vel));
			if (got.fin !== e.fin)
				report_error($sformatf("motor %0d last got %0b want %0b",
					e.id, got.fin, e.fin));
			matched++;
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [2:0] action = 0;
	logic [3:0] motor = 0;
	logic signed [31:0] command_value = 0;
	logic out_valid, out_stall = 0;
	logic [3:0] motor_id;
	logic signed [31:0] position, velocity;
	logic last;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	motor_plant_simulator #(.MOTORS(NMOT), .SINE_TABLE_BITS(TBITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .motor(motor),
		.command_value(command_value),
		.out_valid(out_valid), .out_stall(out_stall), .motor_id(motor_id),
		.position(position), .velocity(velocity), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	motor_scoreboard board = new();
	int cycles = 0;
	int items_sent = 0;
	bit hold_long = 0;   // receiver holds off entirely while set
	bit stall_busy = 0;  // receiver pattern on or off

	// Cycle counter: a timeout that fails and ends the run once the count passes LIMIT.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Sample the output channel; a transaction moves on valid with stall low.
	always @(posedge clk) begin
		motor_report_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.id = motor_id; got.pos = position; got.vel = velocity; got.fin = last;
			board.check_output(got);
		end
	end

	// Receiver stall pattern: random stalls in some stretches, none in others,
	// and a long hold-off whenever the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_long) out_stall <= 1'b1;
		else if (stall_busy) out_stall <= ($urandom_range(0, 2) == 0);
		else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_busy <= ~stall_busy;
	end

	// Offer one input transaction and hold it until the block takes it.
	task automatic send_item(input logic [2:0] act, input logic [3:0] m,
			input logic signed [31:0] val);
		action <= act; motor <= m; command_value <= val; in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_input(act, m, val);
		items_sent++;
	endtask

	// Drop valid between bursts for a random gap.
	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for every expectation to drain, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_index <= idx; cfg_data <= d; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 65535 * 4)) - 32'sd131072;
			default: return $signed($urandom);
		endcase
	endfunction

	// Random bursts: a random mix of commands, ticks, reads, idles and unused codes, then a drain.
	task automatic random_phase(input int count);
		int burst;
		logic [2:0] a;
		burst = $urandom_range(1, 8);
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: a = 3'($urandom_range(mps_pkg::ACT_POS, mps_pkg::ACT_TRQ));
				3, 4, 5: a = mps_pkg::ACT_TICK;
				6, 7: a = mps_pkg::ACT_READ;
				8: a = mps_pkg::ACT_IDLE;
				default: a = 3'($urandom_range(6, 7));
			endcase
			send_item(a, 4'($urandom), rand_value());
			if (--burst == 0) begin
				idle_gap($urandom_range(1, 20));
				burst = $urandom_range(1, 8);
			end
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: every action, value extremes, unused codes, reads in idle and position mode.
		send_item(mps_pkg::ACT_READ, 4'd0, 0);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(mps_pkg::ACT_POS, 4'd0, 32'sh7fffffff);
		send_item(mps_pkg::ACT_POS, 4'd15, 32'sh80000000);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(mps_pkg::ACT_READ, 4'd15, 0);
		send_item(mps_pkg::ACT_VEL, 4'd3, 32'sh7fffffff);
		send_item(mps_pkg::ACT_VEL, 4'd4, 32'sh80000000);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(mps_pkg::ACT_TRQ, 4'd5, 32'sh7fffffff);
		send_item(mps_pkg::ACT_TRQ, 4'd6, 32'sh80000000);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(3'd6, 4'd1, 32'sh12345678);
		send_item(3'd7, 4'd2, 32'shedcba987);
		send_item(mps_pkg::ACT_IDLE, 4'd0, 0);
		send_item(mps_pkg::ACT_TICK, 4'd0, 0);
		send_item(mps_pkg::ACT_READ, 4'd5, 0);
		drain();

		// Extremes of every register, including alpha above one and zero 1/dt.
		write_reg(mps_pkg::CFG_TICK_PERIOD, 32'hffffffff);
		write_reg(mps_pkg::CFG_LAG_ALPHA, 32'h1ffff);
		write_reg(mps_pkg::CFG_INV_PERIOD, 32'h7fffffff);
		write_reg(mps_pkg::CFG_TORQUE_STEP, 32'hffffffff);
		write_reg(mps_pkg::CFG_DIST_AMP, 32'h7fffffff);
		write_reg(mps_pkg::CFG_PHASE_STEP, 32'h80000000);
		random_phase(45);

		write_reg(mps_pkg::CFG_TICK_PERIOD, 0);
		write_reg(mps_pkg::CFG_LAG_ALPHA, 0);
		write_reg(mps_pkg::CFG_INV_PERIOD, 0);
		write_reg(mps_pkg::CFG_TORQUE_STEP, 0);
		write_reg(mps_pkg::CFG_DIST_AMP, 0);
		write_reg(mps_pkg::CFG_PHASE_STEP, 0);
		random_phase(30);

		// Long receiver hold-off while the sender keeps offering ticks.
		fork
			begin
				hold_long = 1;
				repeat (600) @(posedge clk);
				hold_long = 0;
			end
			repeat (6) send_item(mps_pkg::ACT_TICK, 4'($urandom), $urandom);
		join
		drain();

		write_reg(mps_pkg::CFG_TICK_PERIOD, $urandom);
		write_reg(mps_pkg::CFG_LAG_ALPHA, $urandom_range(0, 65536));
		write_reg(mps_pkg::CFG_INV_PERIOD, $urandom);
		write_reg(mps_pkg::CFG_TORQUE_STEP, $urandom);
		write_reg(mps_pkg::CFG_DIST_AMP, $urandom_range(0, 200000));
		write_reg(mps_pkg::CFG_PHASE_STEP, $urandom);
		random_phase(80);

		$display("Covered %0d input items and %0d checked results", items_sent, board.matched);
		$display("across four register settings, all actions and a long output hold-off.");
		if (errors == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
